// File: src/modular_exponentiation_macros.svh
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define MODEXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MODEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MODEXP_ASSERT_NOW(lbl, ante, cons, msg)
`define MODEXP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

  // Payload and register widths
  localparam int DATA_W = 32;
  localparam int EXP_W  = 32;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;

  // Remainder unit: 64-bit dividend, two quotient bits per cycle
  localparam int DVD_W         = 64;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = DVD_W / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  // Register map, selected by paddr[2]
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  localparam logic [EXP_W-1:0] EXP_RESET = 32'd65537;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_RED  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // What the remainder unit is currently producing
  typedef enum logic [1:0] {
    OP_BASE = 2'd0,
    OP_ACC  = 2'd1,
    OP_SQR  = 2'd2
  } op_t;

endpackage

`default_nettype wire

// File: src/modexp_if.sv
// Valid/ready channel interfaces for the base and result beats.
`default_nettype none

interface modexp_in_if;
  import modexp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  modport source (output valid, output base, input ready);
  modport sink   (input valid, input base, output ready);
endinterface

interface modexp_out_if;
  import modexp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// File: src/modular_exponentiation.sv
// Modular exponentiation (right-to-left square-and-multiply) with APB config.
// One base beat in, one result beat out: result = base^exponent mod modulus, using
// the exponent and modulus registers (APB byte address 0 and 4). The block takes
// one beat at a time, holds ready low until its result has been taken and is ready
// again the cycle after that. Every modular multiply runs on a MOD_BITS x MOD_BITS
// multiplier and is then reduced on a shared restoring remainder unit that retires
// two dividend bits per cycle; that unit sets the rate. The base is first reduced.
// An exponent of zero answers 1, and a modulus of zero with a nonzero exponent
// answers 0, in the cycle after accept. There is no clearing pass after reset.
`default_nettype none

`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
  parameter int MOD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  modexp_in_if.sink                     in_ch,
  modexp_out_if.source                  out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [modexp_pkg::ADDR_W-1:0] paddr,
  input  logic [modexp_pkg::APB_W-1:0]  pwdata,
  output logic [modexp_pkg::APB_W-1:0]  prdata,
  output logic                          pready
);
  import modexp_pkg::*;

  // Configuration registers
  logic [EXP_W-1:0]    exp_cfg_r;
  logic [MOD_BITS-1:0] mod_cfg_r;

  // Sequencer and datapath registers
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [EXP_W-1:0]    e_r, e_nxt;
  logic [MOD_BITS-1:0] m_r, m_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] pw_r, pw_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [MOD_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                  cfg_wr;
  logic                  in_fire;
  logic                  out_fire;
  logic [MOD_BITS-1:0]   mul_a;
  logic [2*MOD_BITS-1:0] prod;
  logic [MOD_BITS-1:0]   red_rem;
  logic                  red_last;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cfg_r <= EXP_RESET;
      mod_cfg_r <= MOD_BITS'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_EXPONENT) begin
        exp_cfg_r <= pwdata[EXP_W-1:0];
      end else begin
        mod_cfg_r <= pwdata[MOD_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MODULUS) begin
      prdata = APB_W'(mod_cfg_r);
    end else begin
      prdata = APB_W'(exp_cfg_r);
    end
  end

  // Handshakes
  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = (state_r == S_DONE);
  assign out_ch.result = DATA_W'(acc_r);
  assign in_fire       = in_ch.valid & in_ch.ready;
  assign out_fire      = out_ch.valid & out_ch.ready;

  // Shared multiplier: acc*pw or pw*pw
  assign mul_a = (op_r == OP_ACC) ? acc_r : pw_r;
  assign prod  = mul_a * pw_r;

  // Remainder unit: two restoring steps per cycle
  always_comb begin
    logic [MOD_BITS:0]   trial;
    logic [MOD_BITS-1:0] r;
    r = rem_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {r, dvd_r[DVD_W-1-i]};
      if (trial >= {1'b0, m_r}) begin
        trial = trial - {1'b0, m_r};
      end
      r = trial[MOD_BITS-1:0];
    end
    red_rem = r;
  end

  assign red_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    acc_nxt   = acc_r;
    pw_nxt    = pw_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          e_nxt   = exp_cfg_r;
          m_nxt   = mod_cfg_r;
          dvd_nxt = DVD_W'(in_ch.base);
          rem_nxt = '0;
          cnt_nxt = '0;
          op_nxt  = OP_BASE;
          if (exp_cfg_r == '0) begin
            acc_nxt   = MOD_BITS'(1);
            state_nxt = S_DONE;
          end else if (mod_cfg_r == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            acc_nxt   = MOD_BITS'(1);
            state_nxt = S_RED;
          end
        end
      end
      S_MUL: begin
        dvd_nxt   = DVD_W'(prod);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_RED;
      end
      S_RED: begin
        rem_nxt = red_rem;
        dvd_nxt = dvd_r << BITS_PER_STEP;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (red_last) begin
          if (op_r == OP_ACC) begin
            acc_nxt = red_rem;
          end else begin
            pw_nxt = red_rem;
          end
          // Multiply for a set bit, else square toward the next bit
          if (op_r != OP_ACC && e_r[0]) begin
            op_nxt    = OP_ACC;
            state_nxt = S_MUL;
          end else if (e_r[EXP_W-1:1] != '0) begin
            e_nxt     = e_r >> 1;
            op_nxt    = OP_SQR;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_BASE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    pw_r  <= pw_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  // Checks
  `MODEXP_ASSERT_NOW(a_rem_below_mod, state_r == S_RED, rem_r < m_r, "remainder not below modulus")
  `MODEXP_ASSERT_NEXT(a_mul_then_red, state_r == S_MUL,
    state_r == S_RED && cnt_r == '0, "multiply not followed by a fresh reduction")
  `MODEXP_ASSERT_NEXT(a_out_to_idle, out_fire, in_ch.ready && !out_ch.valid,
    "result beat taken but block not idle")
  `MODEXP_ASSERT_NOW(a_mul_operands, state_r == S_MUL,
    pw_r < m_r && (op_r == OP_SQR || acc_r <= m_r), "multiplier operand not reduced")

endmodule

`default_nettype wire
